[src/iso2ep_pkg.sv]
// Shared types, constants and the month offset table for the timestamp to epoch block.
`default_nettype none

package iso2ep_pkg;

    localparam int ACC_W   = 40;
    localparam int EPOCH_W = 38;
    localparam int YEAR_W  = 14;
    localparam int FLD_W   = 12;
    localparam int CNT_W   = 5;

    // ASCII characters the parser checks against
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_DASH  = 8'd45;
    localparam logic [7:0] CH_T     = 8'd84;
    localparam logic [7:0] CH_COLON = 8'd58;

    // Date arithmetic constants
    localparam logic [17:0] ERA_DAYS     = 18'd146097;
    localparam logic [19:0] EPOCH_SHIFT  = 20'd719468;
    localparam logic [16:0] DAY_SECS     = 17'd86400;
    localparam logic [11:0] HOUR_SECS    = 12'd3600;
    localparam logic [5:0]  MIN_SECS     = 6'd60;
    localparam logic [8:0]  YEAR_DAYS    = 9'd365;
    localparam logic [8:0]  ERA_YEARS    = 9'd400;
    localparam logic [13:0] YEAR_MIN     = 14'd1970;
    // floor(y / 400) == (y * 5243) >> 21 for every y below 2**14
    localparam logic [12:0] ERA_RECIP    = 13'd5243;
    localparam int          ERA_RECIP_SH = 21;
    localparam int          ERA_W        = 5;
    localparam int          YOE_W        = 9;

    // Range-checked date and time fields handed to the arithmetic unit
    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
    } date_t;

    // Status of the arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } calc_stat_t;

    // Days from March 1 to the first of the month, March-based year
    function automatic logic [8:0] month_offset(input logic [3:0] month);
        logic [8:0] off;
        unique case (month)
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

[src/iso_utc_timestamp_to_epoch_top.sv]
// Top level: streaming ISO 8601 UTC timestamp parser with epoch seconds result.
//
// Input channel: one ASCII character per item on char_byte, last_char marks the
// final character of a string. Items are taken when in_valid is high and
// in_stall is low. Output channel: one item per string on valid_res and
// epoch_seconds, taken when out_valid is high and out_stall is low.
// Every character but the last is taken one per cycle, back to back, unless
// the arithmetic unit is busy. A last character of a string that fails the
// format or range checks gives a result in the next cycle. A string that passes
// runs through an eight-step sequence on one shared multiply-accumulate unit:
// its result is loaded in the DONE step, and no character is taken meanwhile.
// The output register holds a result until it is taken; characters that are
// not last keep flowing while it waits, a last character stalls until it is
// free. Reset clears the parser position, flags, sequencer and out_valid.
`default_nettype none

module iso_utc_timestamp_to_epoch_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [7:0]                   char_byte,
    input  wire logic                         last_char,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              valid_res,
    output logic [iso2ep_pkg::EPOCH_W-1:0]    epoch_seconds
);
    import iso2ep_pkg::*;

    // Character positions within the string
    localparam logic [CNT_W-1:0] POS_Y0  = 5'd0;
    localparam logic [CNT_W-1:0] POS_Y1  = 5'd1;
    localparam logic [CNT_W-1:0] POS_Y2  = 5'd2;
    localparam logic [CNT_W-1:0] POS_Y3  = 5'd3;
    localparam logic [CNT_W-1:0] POS_D1  = 5'd4;
    localparam logic [CNT_W-1:0] POS_MO0 = 5'd5;
    localparam logic [CNT_W-1:0] POS_MO1 = 5'd6;
    localparam logic [CNT_W-1:0] POS_D2  = 5'd7;
    localparam logic [CNT_W-1:0] POS_DA0 = 5'd8;
    localparam logic [CNT_W-1:0] POS_DA1 = 5'd9;
    localparam logic [CNT_W-1:0] POS_T   = 5'd10;
    localparam logic [CNT_W-1:0] POS_H0  = 5'd11;
    localparam logic [CNT_W-1:0] POS_H1  = 5'd12;
    localparam logic [CNT_W-1:0] POS_C1  = 5'd13;
    localparam logic [CNT_W-1:0] POS_MI0 = 5'd14;
    localparam logic [CNT_W-1:0] POS_MI1 = 5'd15;
    localparam logic [CNT_W-1:0] POS_C2  = 5'd16;
    localparam logic [CNT_W-1:0] POS_S0  = 5'd17;
    localparam logic [CNT_W-1:0] POS_S1  = 5'd18;
    localparam logic [CNT_W-1:0] POS_END = 5'd19;
    localparam logic [CNT_W-1:0] POS_SAT = 5'd20;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              bad_reg, bad_next;
    logic [YEAR_W-1:0] year_reg, year_next;
    logic [FLD_W-1:0]  month_reg, month_next;
    logic [FLD_W-1:0]  day_reg, day_next;
    logic [FLD_W-1:0]  hour_reg, hour_next;
    logic [FLD_W-1:0]  minute_reg, minute_next;
    logic [FLD_W-1:0]  second_reg, second_next;

    logic               out_valid_reg, out_valid_next;
    logic               valid_res_reg;
    logic [EPOCH_W-1:0] epoch_reg;

    logic               in_acc;
    logic               out_acc;
    logic               out_free;
    logic               is_digit;
    logic               below_zero;
    logic [7:0]         dig;
    logic [FLD_W-1:0]   dig_x10;
    logic [FLD_W-1:0]   dig_w;
    logic               fields_ok;
    logic               calc_start;
    logic               early_bad;
    logic               calc_ack;
    date_t              date_w;
    calc_stat_t         calc_stat;
    logic [EPOCH_W-1:0] calc_secs;

    // Handshakes
    assign out_acc  = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = calc_stat.busy || (last_char && !out_free);
    assign in_acc   = in_valid && !in_stall;

    // Classify the character
    assign dig        = char_byte - CH_ZERO;
    assign is_digit   = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    assign below_zero = (char_byte < CH_ZERO);
    assign dig_w      = FLD_W'(dig);
    assign dig_x10    = FLD_W'(dig_w * 12'd10);

    // Fold the character into the field its position selects
    always_comb
    begin
        count_next  = count_reg;
        bad_next    = bad_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        if (in_acc)
        begin
            unique case (count_reg)
                POS_Y0, POS_Y1, POS_Y2, POS_Y3:
                begin
                    if (!is_digit)
                        bad_next = 1'b1;
                    else
                        year_next = YEAR_W'(year_reg * 14'd10 + YEAR_W'(dig));
                end
                POS_D1, POS_D2:
                    if (char_byte != CH_DASH) bad_next = 1'b1;
                POS_T:
                    if (char_byte != CH_T) bad_next = 1'b1;
                POS_C1, POS_C2:
                    if (char_byte != CH_COLON) bad_next = 1'b1;
                POS_MO0:
                    if (below_zero) bad_next = 1'b1; else month_next = dig_x10;
                POS_MO1:
                    if (below_zero) bad_next = 1'b1; else month_next = month_reg + dig_w;
                POS_DA0:
                    if (below_zero) bad_next = 1'b1; else day_next = dig_x10;
                POS_DA1:
                    if (below_zero) bad_next = 1'b1; else day_next = day_reg + dig_w;
                POS_H0:
                    if (below_zero) bad_next = 1'b1; else hour_next = dig_x10;
                POS_H1:
                    if (below_zero) bad_next = 1'b1; else hour_next = hour_reg + dig_w;
                POS_MI0:
                    if (below_zero) bad_next = 1'b1; else minute_next = dig_x10;
                POS_MI1:
                    if (below_zero) bad_next = 1'b1; else minute_next = minute_reg + dig_w;
                POS_S0:
                    if (below_zero) bad_next = 1'b1; else second_next = dig_x10;
                POS_S1:
                    if (below_zero) bad_next = 1'b1; else second_next = second_reg + dig_w;
                default:
                begin
                end
            endcase
            if (count_reg < POS_SAT)
                count_next = count_reg + 5'd1;
            // Drop all string state after the last character
            if (last_char)
            begin
                count_next  = '0;
                bad_next    = 1'b0;
                year_next   = '0;
                month_next  = '0;
                day_next    = '0;
                hour_next   = '0;
                minute_next = '0;
                second_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            bad_reg    <= 1'b0;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            bad_reg    <= bad_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
        end
    end

    // Format and range checks on the finished string
    assign fields_ok = (count_reg >= POS_END) && !bad_reg &&
                       (year_reg >= YEAR_MIN) &&
                       (month_reg >= 12'd1) && (month_reg <= 12'd12) &&
                       (day_reg >= 12'd1) && (day_reg <= 12'd31) &&
                       (hour_reg <= 12'd23) && (minute_reg <= 12'd59) &&
                       (second_reg <= 12'd59);

    assign calc_start = in_acc && last_char && fields_ok;
    assign early_bad  = in_acc && last_char && !fields_ok;
    assign calc_ack   = calc_stat.done && out_free;

    assign date_w.year   = year_reg;
    assign date_w.month  = month_reg[3:0];
    assign date_w.day    = day_reg[4:0];
    assign date_w.hour   = hour_reg[4:0];
    assign date_w.minute = minute_reg[5:0];
    assign date_w.second = second_reg[5:0];

    iso2ep_calc u_calc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (calc_start),
        .date  (date_w),
        .ack   (calc_ack),
        .stat  (calc_stat),
        .secs  (calc_secs)
    );

    // Output register: load a rejected string at once, or the finished sum
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_acc)
            out_valid_next = 1'b0;
        if (early_bad || calc_ack)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (early_bad)
        begin
            valid_res_reg <= 1'b0;
            epoch_reg     <= '0;
        end
        else if (calc_ack)
        begin
            valid_res_reg <= 1'b1;
            epoch_reg     <= calc_secs;
        end
    end

    assign out_valid     = out_valid_reg;
    assign valid_res     = valid_res_reg;
    assign epoch_seconds = epoch_reg;

    // A rejected string always reports zero seconds
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> epoch_seconds == '0)
        else $error("rejected item carries nonzero seconds");

    // No character is taken while the arithmetic unit is working
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        calc_stat.busy |-> in_stall)
        else $error("input taken while arithmetic unit busy");

    // The parser restarts at position zero after a last character
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && last_char |=> count_reg == '0 && !bad_reg)
        else $error("parser state not cleared after last item");

    // Passing strings stay below year 10000
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> epoch_seconds < 38'd253402300800)
        else $error("epoch seconds out of range");

    // A finished sum never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(epoch_seconds) && $stable(valid_res))
        else $error("waiting result overwritten");

endmodule

`default_nettype wire

[src/iso2ep_calc.sv]
// Sequenced multiply-accumulate unit that turns a checked date and time into epoch seconds.
`default_nettype none

module iso2ep_calc (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire iso2ep_pkg::date_t            date,
    input  wire logic                         ack,
    output iso2ep_pkg::calc_stat_t            stat,
    output logic [iso2ep_pkg::EPOCH_W-1:0]    secs
);
    import iso2ep_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ERA  = 4'd1;
    localparam logic [3:0] ST_YOE  = 4'd2;
    localparam logic [3:0] ST_DAYS = 4'd3;
    localparam logic [3:0] ST_YEAR = 4'd4;
    localparam logic [3:0] ST_SEC  = 4'd5;
    localparam logic [3:0] ST_HOUR = 4'd6;
    localparam logic [3:0] ST_MIN  = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    logic [3:0]       step_reg, step_next;
    date_t            date_reg;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ERA_W-1:0] era_reg;
    logic [YOE_W-1:0] yoe_reg;

    logic [YEAR_W-1:0] y_w;
    logic [ERA_W-1:0]  era_w;
    logic [YOE_W-1:0]  yoe_w;
    logic [1:0]        cent_w;
    logic [9:0]        doy_w;
    logic [10:0]       pos_sum_w;
    logic [ACC_W-1:0]  base_w;

    logic              mac_en;
    logic              keep;
    logic [22:0]       mul_a;
    logic [17:0]       mul_b;
    logic [ACC_W-1:0]  prod;
    logic [ACC_W-1:0]  add_c;

    // Year shifted to a March start, and its split into era and year of era
    assign y_w   = date_reg.year - YEAR_W'(date_reg.month <= 4'd2);
    assign era_w = acc_reg[ERA_RECIP_SH +: ERA_W];
    assign yoe_w = YOE_W'(y_w - YEAR_W'({9'b0, era_w} * {5'b0, ERA_YEARS}));

    // Leap corrections and day of year, all folded into one addend
    always_comb
    begin
        if (yoe_reg >= 9'd300)
            cent_w = 2'd3;
        else if (yoe_reg >= 9'd200)
            cent_w = 2'd2;
        else if (yoe_reg >= 9'd100)
            cent_w = 2'd1;
        else
            cent_w = 2'd0;
    end

    assign doy_w     = 10'(month_offset(date_reg.month)) + 10'(date_reg.day) - 10'd1;
    assign pos_sum_w = 11'(yoe_reg[YOE_W-1:2]) + 11'(doy_w);
    assign base_w    = ACC_W'(pos_sum_w) - ACC_W'(cent_w) - ACC_W'(EPOCH_SHIFT);

    // Select the operands of the shared multiplier for each step that uses it
    always_comb
    begin
        mac_en = 1'b0;
        keep   = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        add_c  = '0;
        unique case (step_reg)
            ST_ERA:
            begin
                mac_en = 1'b1;
                mul_a  = 23'(y_w);
                mul_b  = 18'(ERA_RECIP);
            end
            ST_DAYS:
            begin
                mac_en = 1'b1;
                mul_a  = 23'(era_reg);
                mul_b  = ERA_DAYS;
                add_c  = base_w;
            end
            ST_YEAR:
            begin
                mac_en = 1'b1;
                keep   = 1'b1;
                mul_a  = 23'(yoe_reg);
                mul_b  = 18'(YEAR_DAYS);
            end
            ST_SEC:
            begin
                mac_en = 1'b1;
                mul_a  = acc_reg[22:0];
                mul_b  = 18'(DAY_SECS);
                add_c  = ACC_W'(date_reg.second);
            end
            ST_HOUR:
            begin
                mac_en = 1'b1;
                keep   = 1'b1;
                mul_a  = 23'(date_reg.hour);
                mul_b  = 18'(HOUR_SECS);
            end
            ST_MIN:
            begin
                mac_en = 1'b1;
                keep   = 1'b1;
                mul_a  = 23'(date_reg.minute);
                mul_b  = 18'(MIN_SECS);
            end
            default:
            begin
                mac_en = 1'b0;
            end
        endcase
    end

    assign prod     = {17'b0, mul_a} * {22'b0, mul_b};
    assign acc_next = (keep ? acc_reg : '0) + prod + add_c;

    // Advance the sequencer
    always_comb
    begin
        step_next = step_reg;
        unique case (step_reg)
            ST_IDLE: if (start) step_next = ST_ERA;
            ST_ERA:  step_next = ST_YOE;
            ST_YOE:  step_next = ST_DAYS;
            ST_DAYS: step_next = ST_YEAR;
            ST_YEAR: step_next = ST_SEC;
            ST_SEC:  step_next = ST_HOUR;
            ST_HOUR: step_next = ST_MIN;
            ST_MIN:  step_next = ST_DONE;
            ST_DONE: if (ack) step_next = ST_IDLE;
            default: step_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= ST_IDLE;
        else
            step_reg <= step_next;
    end

    // Hold operands and the accumulator
    always_ff @(posedge clk)
    begin
        if (step_reg == ST_IDLE && start)
            date_reg <= date;
        if (step_reg == ST_YOE)
        begin
            era_reg <= era_w;
            yoe_reg <= yoe_w;
        end
        if (mac_en)
            acc_reg <= acc_next;
    end

    assign stat.busy = (step_reg != ST_IDLE);
    assign stat.done = (step_reg == ST_DONE);
    assign secs      = acc_reg[EPOCH_W-1:0];

endmodule

`default_nettype wire
